>>> sv/assert_macros.svh
// Assertion macros shared by the queue RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/lapq_pkg.sv
// Shared types and constants for the linear array queue.
// No dependencies; used by linear_array_queue_unit.
package lapq_pkg;

  localparam int DEPTH     = 256;
  localparam int PTR_W     = $clog2(DEPTH + 1);
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W     = 9;
  localparam int CAP_RESET = 256;
  localparam int VAL_W     = 31;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ENQ   = 3'd1;
  localparam logic [2:0] OP_DEQ   = 3'd2;
  localparam logic [2:0] OP_PEEK  = 3'd3;
  localparam logic [2:0] OP_REPL  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NEG   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value_out;
    logic             empty_res;
    logic             full_res;
  } out_item_t;

endpackage

>>> sv/lapq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first: a read and write at the same address return the old data.
module lapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/linear_array_queue_unit.sv
// Linear array queue: top level with pointer control, slot RAM and result register.
// Depends on lapq_pkg, lapq_ram and assert_macros.svh.

// One item per cycle: each opcode is decoded against the head and tail
// pointers in the cycle it is accepted, the pointers update at that edge,
// and the single slot RAM (one write, one registered read) delivers any
// read value together with the registered result. Results sit in an output
// register; a new item is taken whenever that register is empty or being
// drained, so throughput is one item per cycle without output stalls.
// The tail only moves back on clear, so enqueue reports full once the tail
// reaches the capacity, till a clear or a higher limit. Capacity is written through
// cfg_we_i/cfg_wdata_i, resets to 256 and saturates at the array depth.
`include "assert_macros.svh"

module linear_array_queue_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lapq_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lapq_pkg::out_item_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [lapq_pkg::CAP_W-1:0]   cfg_wdata_i
);

  logic [lapq_pkg::CAP_W-1:0]  cap_q;
  logic [lapq_pkg::PTR_W-1:0]  head_q, head_d;
  logic [lapq_pkg::PTR_W-1:0]  tail_q, tail_d;
  logic [lapq_pkg::PTR_W-1:0]  limit;
  logic                        out_valid_q;
  lapq_pkg::status_e           status_q, status_d;
  logic                        use_rd_q, use_rd_d;
  logic                        empty_q, full_q;
  logic                        in_fire;
  logic                        neg;
  logic                        empty_now, at_lim;
  logic                        ram_we, ram_re;
  logic [lapq_pkg::ADDR_W-1:0] ram_waddr;
  logic [lapq_pkg::VAL_W-1:0]  ram_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign limit = (int'(cap_q) > lapq_pkg::DEPTH) ? lapq_pkg::PTR_W'(lapq_pkg::DEPTH)
                                                : lapq_pkg::PTR_W'(cap_q);
  assign neg       = in_item_i.value_in[31];
  assign empty_now = (head_q == tail_q);
  assign at_lim    = (tail_q >= limit);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    status_d  = lapq_pkg::ST_OK;
    use_rd_d  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = tail_q[lapq_pkg::ADDR_W-1:0];
    unique case (in_item_i.opcode) inside
      lapq_pkg::OP_CLEAR: begin
        head_d = '0;
        tail_d = '0;
      end
      lapq_pkg::OP_ENQ: begin
        if (neg) begin
          status_d = lapq_pkg::ST_NEG;
        end else if (at_lim) begin
          status_d = lapq_pkg::ST_FULL;
        end else begin
          ram_we = 1'b1;
          tail_d = tail_q + 1'b1;
        end
      end
      lapq_pkg::OP_DEQ, lapq_pkg::OP_PEEK: begin
        if (empty_now) begin
          status_d = lapq_pkg::ST_EMPTY;
        end else begin
          ram_re   = 1'b1;
          use_rd_d = 1'b1;
          if (in_item_i.opcode == lapq_pkg::OP_DEQ) begin
            head_d = head_q + 1'b1;
          end
        end
      end
      lapq_pkg::OP_REPL: begin
        if (neg) begin
          status_d = lapq_pkg::ST_NEG;
        end else if (empty_now) begin
          status_d = lapq_pkg::ST_EMPTY;
        end else begin
          // read-first RAM hands back the old head while the new one lands
          ram_re    = 1'b1;
          use_rd_d  = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = head_q[lapq_pkg::ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lapq_pkg::CAP_W'(lapq_pkg::CAP_RESET);
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= lapq_pkg::ST_OK;
      use_rd_q    <= 1'b0;
      empty_q     <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        use_rd_q    <= use_rd_d;
        empty_q     <= (head_d == tail_d);
        full_q      <= (tail_d >= limit);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  lapq_ram #(
    .WIDTH (lapq_pkg::VAL_W),
    .DEPTH (lapq_pkg::DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (in_fire && ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_item_i.value_in[lapq_pkg::VAL_W-1:0]),
    .re_i    (in_fire && ram_re),
    .raddr_i (head_q[lapq_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o          = out_valid_q;
  assign out_item_o.status    = status_q;
  assign out_item_o.value_out = use_rd_q ? ram_rdata : '0;
  assign out_item_o.empty_res = empty_q;
  assign out_item_o.full_res  = full_q;

  `ASSERT_ALWAYS(a_head_le_tail, clk_i, rst_ni, head_q <= tail_q)
  `ASSERT_ALWAYS(a_tail_le_depth, clk_i, rst_ni,
                 tail_q <= lapq_pkg::PTR_W'(lapq_pkg::DEPTH))
  `ASSERT_NEXT(a_clear_resets, clk_i, rst_ni,
               in_fire && (in_item_i.opcode == lapq_pkg::OP_CLEAR),
               (head_q == '0) && (tail_q == '0) && empty_q)
  `ASSERT_ALWAYS(a_err_zero_value, clk_i, rst_ni,
                 !out_valid_q || (status_q == lapq_pkg::ST_OK) || (out_item_o.value_out == '0))

endmodule

>>> tb/sv/linear_array_queue_unit_test.sv
// Testbench for linear_array_queue_unit: directed and random opcode streams
// with random gaps on both handshakes, checked against an in-bench queue model.
// Depends on lapq_pkg and the linear_array_queue_unit RTL.
`timescale 1ns / 1ps

module linear_array_queue_unit_test;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4;

  // Tracks the queue contents and the results still owed by the block.
  class queue_scoreboard;
    logic [lapq_pkg::VAL_W-1:0] slots [lapq_pkg::DEPTH];
    int unsigned                head_ptr;
    int unsigned                tail_ptr;
    logic [lapq_pkg::CAP_W-1:0] cap_reg;
    lapq_pkg::out_item_t        owed_results [$];
    int                         errors;

    function new();
      head_ptr = 0;
      tail_ptr = 0;
      cap_reg  = lapq_pkg::CAP_W'(lapq_pkg::CAP_RESET);
      errors   = 0;
    endfunction

    function int unsigned tail_limit();
      return (cap_reg > lapq_pkg::DEPTH) ? lapq_pkg::DEPTH : cap_reg;
    endfunction

    function void set_capacity(logic [lapq_pkg::CAP_W-1:0] c);
      cap_reg = c;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void note_item(lapq_pkg::in_item_t it);
      lapq_pkg::out_item_t        exp;
      lapq_pkg::status_e          st;
      logic                       neg;
      logic [lapq_pkg::VAL_W-1:0] val;
      logic                       was_empty;
      exp       = '0;
      st        = lapq_pkg::ST_OK;
      neg       = it.value_in[31];
      val       = it.value_in[lapq_pkg::VAL_W-1:0];
      was_empty = (head_ptr == tail_ptr);
      case (it.opcode) inside
        lapq_pkg::OP_CLEAR: begin
          head_ptr = 0;
          tail_ptr = 0;
        end
        lapq_pkg::OP_ENQ: begin
          if (neg) st = lapq_pkg::ST_NEG;
          else if (tail_ptr >= tail_limit()) st = lapq_pkg::ST_FULL;
          else begin
            slots[tail_ptr] = val;
            tail_ptr++;
          end
        end
        lapq_pkg::OP_DEQ, lapq_pkg::OP_PEEK: begin
          if (was_empty) st = lapq_pkg::ST_EMPTY;
          else begin
            exp.value_out = slots[head_ptr];
            if (it.opcode == lapq_pkg::OP_DEQ) head_ptr++;
          end
        end
        lapq_pkg::OP_REPL: begin
          if (neg) st = lapq_pkg::ST_NEG;
          else if (was_empty) st = lapq_pkg::ST_EMPTY;
          else begin
            exp.value_out   = slots[head_ptr];
            slots[head_ptr] = val;
          end
        end
        default: ;
      endcase
      exp.status    = st;
      exp.empty_res = (head_ptr == tail_ptr);
      exp.full_res  = (tail_ptr >= tail_limit());
      owed_results.push_back(exp);
    endfunction

    function void check_result(lapq_pkg::out_item_t got);
      lapq_pkg::out_item_t exp;
      if (owed_results.size() == 0) begin
        $error("result with nothing expected: status %0d value_out %0h",
               got.status, got.value_out);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.value_out !== exp.value_out) begin
        $error("value_out: expected %0h, got %0h", exp.value_out, got.value_out);
        errors++;
      end
      if (got.empty_res !== exp.empty_res) begin
        $error("empty_res: expected %0b, got %0b", exp.empty_res, got.empty_res);
        errors++;
      end
      if (got.full_res !== exp.full_res) begin
        $error("full_res: expected %0b, got %0b", exp.full_res, got.full_res);
        errors++;
      end
    endfunction

    function void check_drained();
      if (owed_results.size() != 0) begin
        $error("%0d results never arrived", owed_results.size());
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  lapq_pkg::in_item_t         in_item_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  lapq_pkg::out_item_t        out_item_o;
  logic                       cfg_we_i    = 1'b0;
  logic [lapq_pkg::CAP_W-1:0] cfg_wdata_i = '0;

  bit               burst_mode  = 1'b0;
  bit               hold_req    = 1'b0;
  queue_scoreboard  board       = new();

  linear_array_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly back to back, sometimes short gaps, rarely long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom | 32'h8000_0000;
    if (r < 14) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom & 32'h7FFF_FFFF;
  endfunction

  // Valid is only dropped when a gap follows, so back-to-back items keep it high.
  task automatic push_item(input logic [2:0] op, input logic [31:0] val);
    lapq_pkg::in_item_t it;
    int                 gap;
    it.opcode   = op;
    it.value_in = val;
    gap         = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(it);
  endtask

  task automatic write_capacity(input logic [lapq_pkg::CAP_W-1:0] c);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= c;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_capacity(c);
  endtask

  task automatic run_phase(input logic [lapq_pkg::CAP_W-1:0] cap, input int n,
                           input int enq_pct, input int clear_pct,
                           input bit start_clear, input int hold_at);
    int         r;
    logic [2:0] op;
    write_capacity(cap);
    if (start_clear) push_item(lapq_pkg::OP_CLEAR, 32'd0);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < clear_pct) op = lapq_pkg::OP_CLEAR;
      else if (r < clear_pct + 2) op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else if (r < clear_pct + 2 + enq_pct) op = lapq_pkg::OP_ENQ;
      else begin
        case ($urandom_range(0, 3)) inside
          0, 1: op = lapq_pkg::OP_DEQ;
          2: op = lapq_pkg::OP_PEEK;
          default: op = lapq_pkg::OP_REPL;
        endcase
      end
      push_item(op, rand_value());
    end
    burst_mode = 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : drain_results
    int stall;
    int gap;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_item_o);
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          stall = gap - 1;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int guard;
    guard = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: every read-type op fails; negative is reported ahead of empty.
    push_item(lapq_pkg::OP_DEQ, 32'd0);
    push_item(lapq_pkg::OP_PEEK, 32'd0);
    push_item(lapq_pkg::OP_REPL, 32'h8000_0000);
    push_item(lapq_pkg::OP_REPL, 32'd5);
    push_item(lapq_pkg::OP_ENQ, 32'h8000_0000);
    push_item(lapq_pkg::OP_ENQ, 32'd0);
    push_item(lapq_pkg::OP_ENQ, 32'h7FFF_FFFF);
    push_item(lapq_pkg::OP_ENQ, 32'h5555_5555);
    push_item(lapq_pkg::OP_PEEK, 32'hFFFF_FFFF);
    push_item(lapq_pkg::OP_REPL, 32'h2AAA_AAAA);
    push_item(lapq_pkg::OP_REPL, 32'hFFFF_FFFF);
    push_item(lapq_pkg::OP_DEQ, 32'd0);
    push_item(lapq_pkg::OP_DEQ, 32'd0);
    push_item(lapq_pkg::OP_DEQ, 32'd0);
    push_item(lapq_pkg::OP_DEQ, 32'd0);
    push_item(OP_UNUSED_LO, 32'd7);
    push_item(OP_UNUSED_HI, 32'hFFFF_FFFF);
    push_item(lapq_pkg::OP_ENQ, 32'd1);
    push_item(lapq_pkg::OP_CLEAR, 32'd0);
    push_item(lapq_pkg::OP_PEEK, 32'd0);

    // Single slot: full sticks after a dequeue until clear.
    write_capacity(9'd1);
    push_item(lapq_pkg::OP_ENQ, 32'd9);
    push_item(lapq_pkg::OP_ENQ, 32'd10);
    push_item(lapq_pkg::OP_ENQ, 32'hFFFF_FFF0);
    push_item(lapq_pkg::OP_DEQ, 32'd0);
    push_item(lapq_pkg::OP_ENQ, 32'd11);
    push_item(lapq_pkg::OP_CLEAR, 32'd0);

    // Zero capacity: always full.
    write_capacity(9'd0);
    push_item(lapq_pkg::OP_ENQ, 32'd3);

    // Capacity above depth saturates; then drop it below the tail.
    write_capacity(9'd511);
    push_item(lapq_pkg::OP_ENQ, 32'd100);
    push_item(lapq_pkg::OP_ENQ, 32'd200);
    push_item(lapq_pkg::OP_ENQ, 32'd300);
    write_capacity(9'd2);
    push_item(lapq_pkg::OP_PEEK, 32'd0);
    push_item(lapq_pkg::OP_DEQ, 32'd0);
    push_item(lapq_pkg::OP_ENQ, 32'd4);

    run_phase(9'd256, 400, 75, 0, 1'b1, 60);
    run_phase(9'd3, 70, 45, 12, 1'b0, -1);
    run_phase(9'd511, 70, 55, 2, 1'b0, -1);
    run_phase(9'd0, 70, 45, 12, 1'b0, -1);
    run_phase(9'd1, 70, 45, 15, 1'b0, -1);
    run_phase(9'd300, 70, 55, 2, 1'b1, -1);
    run_phase(9'd12, 70, 45, 8, 1'b0, -1);
    run_phase(9'd2, 70, 45, 12, 1'b0, -1);
    run_phase(9'($urandom_range(1, 64)), 70, 45, 6, 1'b0, -1);

    in_valid_i <= 1'b0;
    while (board.pending() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES * 2) @(posedge clk_i);
    board.check_drained();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule
